@@ rtl/lspd_pkg.sv @@
// Shared types and constants for the light-steering PD drive.
// No dependencies; the files that use it refer to it by scoped names.
package lspd_pkg;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;
   localparam int DT_BITS        = 16;
   localparam int GAIN_BITS      = 16;
   localparam int BASE_BITS      = 8;
   localparam int RANGE_BITS     = 10;
   localparam int SPEED_BITS     = 9;
   localparam int FRAC_BITS      = 13;
   localparam int SPEED_LIMIT    = 255;
   localparam int GS_LIMIT       = 200;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [BASE_BITS-1:0]  BASE_SPEED_RESET  = 8'd100;
   localparam logic [GAIN_BITS-1:0]  PROP_GAIN_RESET   = 16'd410;
   localparam logic [GAIN_BITS-1:0]  DERIV_GAIN_RESET  = 16'd2662;
   localparam logic [RANGE_BITS-1:0] OBSTACLE_CM_RESET = 10'd20;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_BASE_SPEED  = 4'd0,
      REG_PROP_GAIN   = 4'd1,
      REG_DERIV_GAIN  = 4'd2,
      REG_OBSTACLE_CM = 4'd3
   } reg_index_type;

   typedef struct packed {
      logic [BASE_BITS-1:0]  base_speed;
      logic [GAIN_BITS-1:0]  prop_gain;
      logic [GAIN_BITS-1:0]  deriv_gain;
      logic [RANGE_BITS-1:0] obstacle_cm;
   } cfg_type;

endpackage

@@ rtl/lspd_front.sv @@
// Front end: accepts request transactions, flags obstacles and forms the error.
// Depends on lspd_pkg for the configuration struct and field widths.
module lspd_front #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [SAMPLE_BITS-1:0]                req_light_left,
   input  logic [SAMPLE_BITS-1:0]                req_light_right,
   input  logic                                  req_echo_seen,
   input  logic [lspd_pkg::RANGE_BITS-1:0]       req_range_cm,
   input  logic [lspd_pkg::DT_BITS-1:0]          req_elapsed_ms,
   input  lspd_pkg::cfg_type                     cfg,
   output logic                                  push_valid,
   input  logic                                  push_ready,
   output logic                                  push_hit,
   output logic signed [SAMPLE_BITS:0]           push_err,
   output logic [lspd_pkg::DT_BITS-1:0]          push_dt
);

   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   // no echo or a zero range never counts as an obstacle
   assign push_hit = req_echo_seen && (req_range_cm != '0) && (req_range_cm < cfg.obstacle_cm);

   assign push_err = $signed({1'b0, req_light_right}) - $signed({1'b0, req_light_left});

   // zero elapsed time divides as one millisecond
   assign push_dt = (req_elapsed_ms == '0) ? lspd_pkg::DT_BITS'(1) : req_elapsed_ms;

endmodule

@@ rtl/lspd_queue.sv @@
// Small register FIFO that decouples the front end from the back end.
// Depends on nothing; width and depth come in as parameters.
module lspd_queue #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNTW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

@@ rtl/lspd_back.sv @@
// Back end: PD arithmetic sequencer with a bit-serial divider and output register.
// Depends on lspd_pkg for constants and the configuration struct.
module lspd_back #(
   parameter int SAMPLE_BITS = 12,
   parameter int DUTY_BITS   = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lspd_pkg::cfg_type                      cfg,
   input  logic                                   ent_valid,
   output logic                                   ent_ready,
   input  logic                                   ent_hit,
   input  logic signed [SAMPLE_BITS:0]            ent_err,
   input  logic [lspd_pkg::DT_BITS-1:0]           ent_dt,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [lspd_pkg::SPEED_BITS-1:0] rsp_left_speed,
   output logic signed [lspd_pkg::SPEED_BITS-1:0] rsp_right_speed,
   output logic                                   rsp_obstacle_hit,
   output logic [DUTY_BITS-1:0]                   rsp_left_duty_a,
   output logic [DUTY_BITS-1:0]                   rsp_left_duty_b,
   output logic [DUTY_BITS-1:0]                   rsp_left_duty_c,
   output logic [DUTY_BITS-1:0]                   rsp_left_duty_d,
   output logic [DUTY_BITS-1:0]                   rsp_right_duty_a,
   output logic [DUTY_BITS-1:0]                   rsp_right_duty_b,
   output logic [DUTY_BITS-1:0]                   rsp_right_duty_c,
   output logic [DUTY_BITS-1:0]                   rsp_right_duty_d
);

   localparam int EW   = SAMPLE_BITS + 1;           // error
   localparam int DFW  = EW + 1;                    // error difference
   localparam int NW   = DFW + lspd_pkg::GAIN_BITS + 1; // signed derivative product
   localparam int MW   = DFW + lspd_pkg::GAIN_BITS; // product magnitude and quotient
   localparam int PW   = EW + lspd_pkg::GAIN_BITS + 1;  // proportional product
   localparam int VW   = DFW + 18;                  // P + D
   localparam int UW   = VW + 2;                    // scaled control value
   localparam int SW   = UW + 1;                    // wheel sum before scaling
   localparam int CW   = $clog2(MW);
   localparam int SPW  = lspd_pkg::SPEED_BITS;
   localparam int MAGW = (DUTY_BITS > SPW - 1) ? DUTY_BITS : SPW - 1;
   localparam int DTW  = lspd_pkg::DT_BITS;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_MUL  = 6'b000010,
      S_DIV  = 6'b000100,
      S_SUM  = 6'b001000,
      S_SPD  = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   function automatic logic signed [SPW-1:0] speed_of(input logic signed [SW-1:0] s);
      logic signed [SW-1:0] adj;
      logic signed [SW-1:0] q;
      logic signed [SW-1:0] res;
      adj = s[SW-1] ? s + SW'((1 << lspd_pkg::FRAC_BITS) - 1) : s;
      q   = adj >>> lspd_pkg::FRAC_BITS;
      if (q > $signed(SW'(lspd_pkg::SPEED_LIMIT))) begin
         res = SW'(lspd_pkg::SPEED_LIMIT);
      end else if (q < -$signed(SW'(lspd_pkg::SPEED_LIMIT))) begin
         res = -$signed(SW'(lspd_pkg::SPEED_LIMIT));
      end else begin
         res = q;
      end
      return res[SPW-1:0];
   endfunction

   function automatic logic [DUTY_BITS-1:0] duty_of(input logic signed [SPW-1:0] s);
      logic [SPW-1:0]  mag;
      logic [MAGW-1:0] mag_ext;
      logic [MAGW-1:0] lim;
      mag     = s[SPW-1] ? -s : s;
      mag_ext = MAGW'(mag[SPW-2:0]);
      lim     = MAGW'({DUTY_BITS{1'b1}});
      return (mag_ext > lim) ? lim[DUTY_BITS-1:0] : mag_ext[DUTY_BITS-1:0];
   endfunction

   state_type              state_ff, state_in;
   logic signed [EW-1:0]   prior_ff, prior_in;
   logic signed [EW-1:0]   err_ff;
   logic [DTW-1:0]         dt_ff;
   logic                   hit_ff;
   logic                   small_ff;
   logic signed [PW-1:0]   p_ff;
   logic                   neg_ff;
   logic [MW-1:0]          quo_ff;
   logic [DTW-1:0]         rem_ff;
   logic [CW-1:0]          cnt_ff;
   logic signed [UW-1:0]   u_ff;
   logic signed [SPW-1:0]  ls_ff, rs_ff;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic signed [DFW-1:0]  diff;
   logic signed [NW-1:0]   num;
   logic [NW-1:0]          num_mag;
   logic signed [PW-1:0]   p_prod;
   logic [EW-1:0]          abs_err;
   logic [DTW:0]           rem_sh;
   logic                   rem_ge;
   logic [DTW:0]           rem_sub;
   logic signed [VW-1:0]   q_s, d_s, v_s;
   logic signed [UW-1:0]   v_ext, u_val;
   logic signed [SW-1:0]   b13, u_ext;
   logic                   load_out;

   assign ent_ready = (state_ff == S_IDLE);
   assign load_out  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   // derivative and proportional products
   always_comb begin
      diff    = $signed({err_ff[EW-1], err_ff}) - $signed({prior_ff[EW-1], prior_ff});
      num     = $signed({1'b0, cfg.deriv_gain}) * diff;
      num_mag = num[NW-1] ? -num : num;
      p_prod  = $signed({1'b0, cfg.prop_gain}) * err_ff;
      abs_err = err_ff[EW-1] ? -err_ff : err_ff;
   end

   // one quotient bit per step, restoring
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[MW-1]};
      rem_ge  = rem_sh >= {1'b0, dt_ff};
      rem_sub = rem_sh - {1'b0, dt_ff};
   end

   // combine P and D, apply the gain schedule (u kept in units of 2^-13)
   always_comb begin
      q_s   = $signed({{(VW - MW){1'b0}}, quo_ff});
      d_s   = neg_ff ? -q_s : q_s;
      v_s   = $signed({{(VW - PW){p_ff[PW-1]}}, p_ff}) + d_s;
      v_ext = {{(UW - VW){v_s[VW-1]}}, v_s};
      u_val = small_ff ? (v_ext <<< 1) + v_ext : (v_ext <<< 1);
      b13   = $signed({{(SW - lspd_pkg::BASE_BITS - lspd_pkg::FRAC_BITS){1'b0}},
                       cfg.base_speed, {lspd_pkg::FRAC_BITS{1'b0}}});
      u_ext = {{(SW - UW){u_ff[UW-1]}}, u_ff};
   end

   always_comb begin
      state_in     = state_ff;
      prior_in     = prior_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (ent_valid) begin
               if (ent_hit) begin
                  prior_in = '0;
                  state_in = S_DONE;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            prior_in = err_ff;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (cnt_ff == '0) begin
               state_in = S_SUM;
            end
         end
         S_SUM: state_in = S_SPD;
         S_SPD: state_in = S_DONE;
         S_DONE: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prior_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prior_ff     <= prior_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            err_ff <= ent_err;
            dt_ff  <= ent_dt;
            hit_ff <= ent_hit;
            ls_ff  <= -$signed({1'b0, cfg.base_speed});
            rs_ff  <= -$signed({1'b0, cfg.base_speed});
         end
         S_MUL: begin
            p_ff     <= p_prod;
            neg_ff   <= num[NW-1];
            quo_ff   <= num_mag[MW-1:0];
            rem_ff   <= '0;
            cnt_ff   <= CW'(MW - 1);
            small_ff <= (abs_err < EW'(lspd_pkg::GS_LIMIT));
         end
         S_DIV: begin
            rem_ff <= rem_ge ? rem_sub[DTW-1:0] : rem_sh[DTW-1:0];
            quo_ff <= {quo_ff[MW-2:0], rem_ge};
            cnt_ff <= cnt_ff - 1'b1;
         end
         S_SUM: begin
            u_ff <= u_val;
         end
         S_SPD: begin
            ls_ff <= speed_of(b13 - u_ext);
            rs_ff <= speed_of(b13 + u_ext);
         end
         default: begin
         end
      endcase
   end

   // output register; legs: left fwd a,d rev b,c; right fwd b,d rev a,c
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_left_speed   <= ls_ff;
         rsp_right_speed  <= rs_ff;
         rsp_obstacle_hit <= hit_ff;
         rsp_left_duty_a  <= (ls_ff > 0) ? duty_of(ls_ff) : '0;
         rsp_left_duty_d  <= (ls_ff > 0) ? duty_of(ls_ff) : '0;
         rsp_left_duty_b  <= (ls_ff < 0) ? duty_of(ls_ff) : '0;
         rsp_left_duty_c  <= (ls_ff < 0) ? duty_of(ls_ff) : '0;
         rsp_right_duty_b <= (rs_ff > 0) ? duty_of(rs_ff) : '0;
         rsp_right_duty_d <= (rs_ff > 0) ? duty_of(rs_ff) : '0;
         rsp_right_duty_a <= (rs_ff < 0) ? duty_of(rs_ff) : '0;
         rsp_right_duty_c <= (rs_ff < 0) ? duty_of(rs_ff) : '0;
      end
   end

   a_hit_equal_reverse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_obstacle_hit |->
         (rsp_left_speed == rsp_right_speed) && (rsp_left_speed <= 0))
      else $error("obstacle result does not reverse both wheels alike");

   a_legs_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_left_duty_a == '0 || rsp_left_duty_b == '0) &&
                       (rsp_right_duty_a == '0 || rsp_right_duty_b == '0))
      else $error("forward and reverse legs driven together");

   a_hit_clears_error: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) && ent_valid && ent_hit |=> (prior_ff == '0))
      else $error("obstacle step did not clear stored error");

   a_div_finishes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) && (cnt_ff == '0) |=> (state_ff == S_SUM))
      else $error("divider did not hand over after its last bit");

endmodule

@@ rtl/light_steering_pd_drive.sv @@
// Light-steering PD drive for a differential robot. Each request transaction
// carries two light samples, a range reading and the elapsed milliseconds; each
// yields one response transaction with signed wheel speeds and four bridge leg
// duties per side. A front end flags obstacles and forms the light error, a
// two-entry queue holds work for the back end, and the back end runs the PD
// arithmetic. A PD step occupies the back end through accept and multiply,
// a bit-serial derivative division, one quotient bit per cycle over
// SAMPLE_BITS + 18 bits, and the combine, speed and hand-off steps. An
// obstacle step goes from accept straight to hand-off. The queue keeps
// accepting requests while the back end is busy or a response waits, until
// both of its entries are full. Registers are written through the csr_ port,
// which is always ready; write only while the block is idle. Indexes beyond
// the four registers are dropped.
// Depends on lspd_pkg, lspd_front, lspd_queue and lspd_back.
module light_steering_pd_drive #(
   parameter int SAMPLE_BITS = 12,
   parameter int DUTY_BITS   = 8
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // configuration writes
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [lspd_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [lspd_pkg::CSR_DATA_BITS-1:0]        csr_data,
   // request channel
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [SAMPLE_BITS-1:0]                    req_light_left,
   input  logic [SAMPLE_BITS-1:0]                    req_light_right,
   input  logic                                      req_echo_seen,
   input  logic [lspd_pkg::RANGE_BITS-1:0]           req_range_cm,
   input  logic [lspd_pkg::DT_BITS-1:0]              req_elapsed_ms,
   // response channel
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [lspd_pkg::SPEED_BITS-1:0]    rsp_left_speed,
   output logic signed [lspd_pkg::SPEED_BITS-1:0]    rsp_right_speed,
   output logic                                      rsp_obstacle_hit,
   output logic [DUTY_BITS-1:0]                      rsp_left_duty_a,
   output logic [DUTY_BITS-1:0]                      rsp_left_duty_b,
   output logic [DUTY_BITS-1:0]                      rsp_left_duty_c,
   output logic [DUTY_BITS-1:0]                      rsp_left_duty_d,
   output logic [DUTY_BITS-1:0]                      rsp_right_duty_a,
   output logic [DUTY_BITS-1:0]                      rsp_right_duty_b,
   output logic [DUTY_BITS-1:0]                      rsp_right_duty_c,
   output logic [DUTY_BITS-1:0]                      rsp_right_duty_d
);

   localparam int EW  = SAMPLE_BITS + 1;
   localparam int DTW = lspd_pkg::DT_BITS;
   localparam int QW  = 1 + EW + DTW;   // queue entry: hit, error, divisor

   lspd_pkg::cfg_type cfg_ff, cfg_in;

   logic                 push_valid, push_ready, push_hit;
   logic signed [EW-1:0] push_err;
   logic [DTW-1:0]       push_dt;
   logic [QW-1:0]        q_in_data, q_out_data;
   logic                 ent_valid, ent_ready;

   // Register file: always ready, unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            lspd_pkg::REG_BASE_SPEED:  cfg_in.base_speed  = csr_data[lspd_pkg::BASE_BITS-1:0];
            lspd_pkg::REG_PROP_GAIN:   cfg_in.prop_gain   = csr_data[lspd_pkg::GAIN_BITS-1:0];
            lspd_pkg::REG_DERIV_GAIN:  cfg_in.deriv_gain  = csr_data[lspd_pkg::GAIN_BITS-1:0];
            lspd_pkg::REG_OBSTACLE_CM: cfg_in.obstacle_cm = csr_data[lspd_pkg::RANGE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_speed  <= lspd_pkg::BASE_SPEED_RESET;
         cfg_ff.prop_gain   <= lspd_pkg::PROP_GAIN_RESET;
         cfg_ff.deriv_gain  <= lspd_pkg::DERIV_GAIN_RESET;
         cfg_ff.obstacle_cm <= lspd_pkg::OBSTACLE_CM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: classify each request and forward it into the queue.
   lspd_front #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_light_left (req_light_left),
      .req_light_right(req_light_right),
      .req_echo_seen  (req_echo_seen),
      .req_range_cm   (req_range_cm),
      .req_elapsed_ms (req_elapsed_ms),
      .cfg            (cfg_ff),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_hit       (push_hit),
      .push_err       (push_err),
      .push_dt        (push_dt)
   );

   assign q_in_data = {push_hit, push_err, push_dt};

   // Hold classified work until the back end is free.
   lspd_queue #(
      .WIDTH(QW),
      .DEPTH(lspd_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (push_valid),
      .in_ready (push_ready),
      .in_data  (q_in_data),
      .out_valid(ent_valid),
      .out_ready(ent_ready),
      .out_data (q_out_data)
   );

   // Back end: PD math, stored error and the response register.
   lspd_back #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .DUTY_BITS  (DUTY_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .ent_valid       (ent_valid),
      .ent_ready       (ent_ready),
      .ent_hit         (q_out_data[QW-1]),
      .ent_err         ($signed(q_out_data[QW-2:DTW])),
      .ent_dt          (q_out_data[DTW-1:0]),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_speed  (rsp_left_speed),
      .rsp_right_speed (rsp_right_speed),
      .rsp_obstacle_hit(rsp_obstacle_hit),
      .rsp_left_duty_a (rsp_left_duty_a),
      .rsp_left_duty_b (rsp_left_duty_b),
      .rsp_left_duty_c (rsp_left_duty_c),
      .rsp_left_duty_d (rsp_left_duty_d),
      .rsp_right_duty_a(rsp_right_duty_a),
      .rsp_right_duty_b(rsp_right_duty_b),
      .rsp_right_duty_c(rsp_right_duty_c),
      .rsp_right_duty_d(rsp_right_duty_d)
   );

endmodule
